@@ rtl/tcce_pkg.sv @@
// shared types, constants and helpers for the text console cursor engine
// no dependencies; used by every rtl file of the block

package tcce_pkg;

    // default geometry, handed to the top level as parameter defaults
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 4;

    // fixed field widths of the ports
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int HEX_W   = 64;
    localparam int CELL_W  = 16;

    // colour byte after reset
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd11;

    // character codes with special meaning
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X         = 8'h78;

    // hex print: "0x" plus sixteen digits
    localparam int HEX_CHARS = 18;
    localparam int HEX_CNT_W = 5;

    // opcodes on the input port
    localparam logic [OP_W-1:0] OPC_PUTC  = 3'd0;
    localparam logic [OP_W-1:0] OPC_PUTAT = 3'd1;
    localparam logic [OP_W-1:0] OPC_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OPC_READ  = 3'd3;
    localparam logic [OP_W-1:0] OPC_HEX   = 3'd4;
    localparam logic [OP_W-1:0] OPC_CR    = 3'd5;

    // command class decided by the front end
    typedef enum logic [2:0] {
        CMD_PUTC,
        CMD_PUTAT,
        CMD_CLEAR,
        CMD_READ,
        CMD_HEX,
        CMD_CR,
        CMD_NOP,
        CMD_REJECT
    } cmd_kind_t;

    // classified command held in the command queue
    typedef struct packed {
        cmd_kind_t            kind;
        logic [CHAR_W-1:0]    char_code;
        logic [COLOR_W-1:0]   cell_color;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [HEX_W-1:0]     hex_value;
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [CELL_W-1:0] read_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              status;
    } result_t;

    // back end controls toward the front end
    typedef struct packed {
        logic cmd_pop;
        logic init_busy;
    } back_ctl_t;

    // uppercase hex glyph of one nibble
    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] glyph;
        if (nib < 4'd10)
        begin
            glyph = CH_ZERO + {4'h0, nib};
        end
        else
        begin
            glyph = 8'h37 + {4'h0, nib};
        end
        return glyph;
    endfunction

endpackage

@@ rtl/tcce_front.sv @@
// front end: classifies input beats and queues them for the back end
// depends on tcce_pkg

module tcce_front #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcce_pkg::OP_W-1:0]     opcode,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::COLOR_W-1:0]  cell_color,
    input  logic [tcce_pkg::ROW_W-1:0]    target_row,
    input  logic [tcce_pkg::COL_W-1:0]    target_col,
    input  logic [tcce_pkg::HEX_W-1:0]    hex_value,
    output tcce_pkg::cmd_t                cmd,
    output logic                          cmd_avail,
    input  tcce_pkg::back_ctl_t           back_ctl
);

    tcce_pkg::cmd_t cmd_in;
    logic           on_screen;
    logic           accept;
    logic           pop;

    tcce_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    // position check against the screen size
    assign on_screen = ({1'b0, target_row} < 6'(ROWS)) && ({1'b0, target_col} < 8'(COLUMNS));

    // classify the beat
    always_comb
    begin
        cmd_in.char_code  = char_code;
        cmd_in.cell_color = cell_color;
        cmd_in.row        = target_row;
        cmd_in.col        = target_col;
        cmd_in.hex_value  = hex_value;
        case (opcode)
            tcce_pkg::OPC_PUTC:  cmd_in.kind = tcce_pkg::CMD_PUTC;
            tcce_pkg::OPC_PUTAT: cmd_in.kind = on_screen ? tcce_pkg::CMD_PUTAT : tcce_pkg::CMD_REJECT;
            tcce_pkg::OPC_CLEAR: cmd_in.kind = tcce_pkg::CMD_CLEAR;
            tcce_pkg::OPC_READ:  cmd_in.kind = on_screen ? tcce_pkg::CMD_READ : tcce_pkg::CMD_REJECT;
            tcce_pkg::OPC_HEX:   cmd_in.kind = tcce_pkg::CMD_HEX;
            tcce_pkg::OPC_CR:    cmd_in.kind = tcce_pkg::CMD_CR;
            default:             cmd_in.kind = tcce_pkg::CMD_NOP;
        endcase
    end

    // queue handshake, held full while the screen is cleared after reset
    assign full      = (count_reg == 2'd2) || back_ctl.init_busy;
    assign accept    = push && !full;
    assign pop       = back_ctl.cmd_pop;
    assign cmd       = entry_reg[rd_ptr_reg];
    assign cmd_avail = (count_reg != 2'd0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ rtl/tcce_outq.sv @@
// result queue: holds finished results until the consumer pops them
// depends on tcce_pkg

module tcce_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_push,
    input  tcce_pkg::result_t             res_in,
    output logic                          res_space,
    output logic                          empty,
    input  logic                          pop,
    output logic [tcce_pkg::CELL_W-1:0]   read_data,
    output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    cursor_col,
    output logic                          status
);

    tcce_pkg::result_t entry_reg [2];
    tcce_pkg::result_t head;
    logic              take;
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    // head of queue drives the result ports
    assign head       = entry_reg[rd_ptr_reg];
    assign read_data  = head.read_data;
    assign cursor_row = head.cursor_row;
    assign cursor_col = head.cursor_col;
    assign status     = head.status;
    assign empty      = (count_reg == 2'd0);
    assign res_space  = (count_reg != 2'd2);
    assign take       = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = res_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (res_push && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !res_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            entry_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

@@ rtl/tcce_back.sv @@
// back end: cursor, screen store and command sequencer
// depends on tcce_pkg; fed by tcce_front, drains into tcce_outq

module tcce_back #(
    parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcce_pkg::COLOR_W-1:0]  text_color,
    input  tcce_pkg::cmd_t                cmd,
    input  logic                          cmd_avail,
    output tcce_pkg::back_ctl_t           back_ctl,
    output logic                          res_push,
    output tcce_pkg::result_t             res,
    input  logic                          res_space
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam logic [7:0] COLS8 = 8'(COLUMNS);
    localparam logic [5:0] ROWS6 = 6'(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_HEX
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [tcce_pkg::ROW_W-1:0]          row_reg;
    logic [tcce_pkg::ROW_W-1:0]          row_next;
    logic [tcce_pkg::COL_W-1:0]          col_reg;
    logic [tcce_pkg::COL_W-1:0]          col_next;
    logic [AW-1:0]                       clr_addr_reg;
    logic [AW-1:0]                       clr_addr_next;
    logic [tcce_pkg::COLOR_W-1:0]        clr_color_reg;
    logic [tcce_pkg::COLOR_W-1:0]        clr_color_next;
    logic                                clr_report_reg;
    logic                                clr_report_next;
    logic [tcce_pkg::HEX_CNT_W-1:0]      hex_cnt_reg;
    logic [tcce_pkg::HEX_CNT_W-1:0]      hex_cnt_next;
    tcce_pkg::cmd_t                      cmd_reg;
    logic [tcce_pkg::HEX_W-1:0]          hex_sh_reg;
    logic [tcce_pkg::HEX_W-1:0]          hex_sh_next;
    logic [tcce_pkg::CELL_W-1:0]         rd_data_reg;

    logic                                cmd_pop;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [tcce_pkg::CELL_W-1:0]         mem_wdata;
    logic                                mem_re;
    logic [AW-1:0]                       mem_raddr;
    logic [tcce_pkg::CELL_W-1:0]         mem [CELL_COUNT];

    logic [tcce_pkg::CHAR_W-1:0]         em_char;
    logic [tcce_pkg::ROW_W-1:0]          em_row;
    logic [tcce_pkg::COL_W-1:0]          em_col;
    logic                                em_we;
    logic [AW-1:0]                       em_waddr;
    logic [tcce_pkg::CELL_W-1:0]         em_wdata;
    logic [7:0]                          reach;
    logic [7:0]                          tab_wrap;
    logic [7:0]                          tab_wrap2;
    logic [7:0]                          tab_wrap3;
    logic [7:0]                          col_inc;
    logic [5:0]                          row_inc;
    logic [tcce_pkg::ROW_W-1:0]          row_adv;

    // linear cell index of a screen position
    function automatic logic [AW-1:0] cell_addr(
        input logic [tcce_pkg::ROW_W-1:0] r,
        input logic [tcce_pkg::COL_W-1:0] c
    );
        logic [AW-1:0] base;
        base = AW'(r) * AW'(COLUMNS);
        return base + AW'(c);
    endfunction

    // character to print: the command's own, or the next hex character
    always_comb
    begin
        if (state_reg == ST_HEX)
        begin
            if (hex_cnt_reg == '0)
            begin
                em_char = tcce_pkg::CH_ZERO;
            end
            else if (hex_cnt_reg == tcce_pkg::HEX_CNT_W'(1))
            begin
                em_char = tcce_pkg::CH_X;
            end
            else
            begin
                em_char = tcce_pkg::hex_glyph(hex_sh_reg[tcce_pkg::HEX_W-1 -: 4]);
            end
        end
        else
        begin
            em_char = cmd_reg.char_code;
        end
    end

    // character rules at the cursor
    always_comb
    begin
        reach     = {1'b0, col_reg} + 8'(TAB_STEP + 1);
        tab_wrap  = reach - COLS8;
        // overshoot is at most TAB_STEP, so two folds bring it on screen
        tab_wrap2 = (tab_wrap >= COLS8) ? (tab_wrap - COLS8) : tab_wrap;
        tab_wrap3 = (tab_wrap2 >= COLS8) ? (tab_wrap2 - COLS8) : tab_wrap2;
        col_inc   = {1'b0, col_reg} + 8'd1;
        row_inc   = {1'b0, row_reg} + 6'd1;
        row_adv   = (row_inc >= ROWS6) ? '0 : row_inc[tcce_pkg::ROW_W-1:0];

        em_row   = row_reg;
        em_col   = col_reg;
        em_we    = 1'b0;
        em_waddr = cell_addr(row_reg, col_reg);
        em_wdata = {text_color, em_char};

        if (em_char == tcce_pkg::CH_NEWLINE)
        begin
            em_row = row_adv;
            em_col = '0;
        end
        else if (em_char == tcce_pkg::CH_TAB)
        begin
            if (reach >= COLS8)
            begin
                em_row = row_adv;
                em_col = tab_wrap3[tcce_pkg::COL_W-1:0];
            end
            else
            begin
                em_col = col_reg + tcce_pkg::COL_W'(TAB_STEP);
            end
        end
        else if (em_char == tcce_pkg::CH_BACKSPACE)
        begin
            if (col_reg != '0)
            begin
                em_col   = col_reg - 7'd1;
                em_we    = 1'b1;
                em_waddr = cell_addr(row_reg, col_reg - 7'd1);
                em_wdata = {text_color, tcce_pkg::CH_SPACE};
            end
        end
        else
        begin
            em_we = 1'b1;
            if (col_inc >= COLS8)
            begin
                em_col = '0;
                em_row = row_adv;
            end
            else
            begin
                em_col = col_inc[tcce_pkg::COL_W-1:0];
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        clr_addr_next   = clr_addr_reg;
        clr_color_next  = clr_color_reg;
        clr_report_next = clr_report_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_sh_next     = hex_sh_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = em_waddr;
        mem_wdata       = em_wdata;
        mem_re          = 1'b0;
        mem_raddr       = cell_addr(cmd_reg.row, cmd_reg.col);
        res_push        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail && res_space)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                state_next = ST_IDLE;
                case (cmd_reg.kind)
                    tcce_pkg::CMD_PUTC:
                    begin
                        row_next  = em_row;
                        col_next  = em_col;
                        mem_we    = em_we;
                        res_push  = 1'b1;
                    end
                    tcce_pkg::CMD_PUTAT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(cmd_reg.row, cmd_reg.col);
                        mem_wdata = {cmd_reg.cell_color, cmd_reg.char_code};
                        res_push  = 1'b1;
                    end
                    tcce_pkg::CMD_CLEAR:
                    begin
                        row_next        = '0;
                        col_next        = '0;
                        clr_addr_next   = '0;
                        clr_color_next  = text_color;
                        clr_report_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    tcce_pkg::CMD_READ:
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_READ;
                    end
                    tcce_pkg::CMD_HEX:
                    begin
                        hex_cnt_next = '0;
                        hex_sh_next  = cmd_reg.hex_value;
                        state_next   = ST_HEX;
                    end
                    tcce_pkg::CMD_CR:
                    begin
                        col_next = '0;
                        res_push = 1'b1;
                    end
                    default:
                    begin
                        res_push = 1'b1;
                    end
                endcase
            end

            ST_READ:
            begin
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_HEX:
            begin
                row_next     = em_row;
                col_next     = em_col;
                mem_we       = em_we;
                hex_cnt_next = hex_cnt_reg + tcce_pkg::HEX_CNT_W'(1);
                if (hex_cnt_reg >= tcce_pkg::HEX_CNT_W'(2))
                begin
                    hex_sh_next = {hex_sh_reg[tcce_pkg::HEX_W-5:0], 4'h0};
                end
                if (hex_cnt_reg == tcce_pkg::HEX_CNT_W'(tcce_pkg::HEX_CHARS - 1))
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = {clr_color_reg, tcce_pkg::CH_SPACE};
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELL_COUNT - 1))
                begin
                    res_push   = clr_report_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat, taken by the result queue when res_push is high
    always_comb
    begin
        res.read_data  = (state_reg == ST_READ) ? rd_data_reg : '0;
        res.cursor_row = row_next;
        res.cursor_col = col_next;
        res.status     = (state_reg == ST_RUN) && (cmd_reg.kind == tcce_pkg::CMD_REJECT);
    end

    assign back_ctl.cmd_pop   = cmd_pop;
    assign back_ctl.init_busy = (state_reg == ST_CLEAR) && !clr_report_reg;

    // control state; reset starts a clearing pass in the reset colour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            clr_addr_reg   <= '0;
            clr_color_reg  <= tcce_pkg::TEXT_COLOR_RESET;
            clr_report_reg <= 1'b0;
            hex_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            clr_addr_reg   <= clr_addr_next;
            clr_color_reg  <= clr_color_next;
            clr_report_reg <= clr_report_next;
            hex_cnt_reg    <= hex_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        hex_sh_reg <= hex_sh_next;
    end

    // screen store write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // screen store read port
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

@@ rtl/text_console_cursor_engine_core.sv @@
// text console engine top: colour register, front end, back end, result queue
// order: a command beat is queued in the front end, popped by the back end in its idle state when the result
// queue has room, carried out in its run state (then its read, hex or clear state as needed), then queued as a result
// the back end carries out one command at a time; hex print and clear make one screen store write per cycle
// reset: cursor to 0,0, colour 11, then a clearing pass over the screen store with full held high
// depends on tcce_pkg, tcce_front, tcce_back, tcce_outq

module text_console_cursor_engine_core #(
    parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcce_pkg::OP_W-1:0]     opcode,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::COLOR_W-1:0]  cell_color,
    input  logic [tcce_pkg::ROW_W-1:0]    target_row,
    input  logic [tcce_pkg::COL_W-1:0]    target_col,
    input  logic [tcce_pkg::HEX_W-1:0]    hex_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [tcce_pkg::CELL_W-1:0]   read_data,
    output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    cursor_col,
    output logic                          status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcce_pkg::COLOR_W-1:0]  cfg_data
);

    logic [tcce_pkg::COLOR_W-1:0] text_color_reg;
    logic [tcce_pkg::COLOR_W-1:0] text_color_next;
    tcce_pkg::cmd_t               cmd;
    logic                         cmd_avail;
    tcce_pkg::back_ctl_t          back_ctl;
    logic                         res_push;
    tcce_pkg::result_t            res;
    logic                         res_space;

    // colour register write beat
    assign cfg_ready       = 1'b1;
    assign text_color_next = (cfg_valid && cfg_ready) ? cfg_data : text_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcce_pkg::TEXT_COLOR_RESET;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    // classify and queue commands
    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_color (cell_color),
        .target_row (target_row),
        .target_col (target_col),
        .hex_value  (hex_value),
        .cmd        (cmd),
        .cmd_avail  (cmd_avail),
        .back_ctl   (back_ctl)
    );

    // carry out commands on cursor and screen store
    tcce_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .cmd        (cmd),
        .cmd_avail  (cmd_avail),
        .back_ctl   (back_ctl),
        .res_push   (res_push),
        .res        (res),
        .res_space  (res_space)
    );

    // results wait here for the consumer
    tcce_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .res_in     (res),
        .res_space  (res_space),
        .empty      (empty),
        .pop        (pop),
        .read_data  (read_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .status     (status)
    );

    // no command beat is taken during the reset clearing pass
    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.init_busy |-> full)
        else $error("command taken during reset clearing pass");

    // the back end never pushes into a full result queue
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_space)
        else $error("result pushed into full result queue");

    // a waiting result always carries a cursor on the screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (({1'b0, cursor_row} < 6'(ROWS)) && ({1'b0, cursor_col} < 8'(COLUMNS))))
        else $error("result cursor outside screen");

    // a rejected command returns no cell data
    a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (read_data == '0))
        else $error("rejected command returned cell data");

endmodule
